### design/kvt_pkg.sv
// kvt_pkg: shared types and constants of the key/value table.
// Used by the interfaces, datapath, controller and top level; depends on nothing.
`timescale 1ns / 1ps

package kvt_pkg;

	localparam int CNT_W    = 5;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 2;

	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cnt_t CAP_RESET = cnt_t'(16);

	localparam cmd_t CMD_PUT      = 3'd0;
	localparam cmd_t CMD_GET      = 3'd1;
	localparam cmd_t CMD_REMOVE   = 3'd2;
	localparam cmd_t CMD_CONTAINS = 3'd3;
	localparam cmd_t CMD_CLEAR    = 3'd4;

	localparam status_t STATUS_OK      = 2'd0;
	localparam status_t STATUS_FULL    = 2'd1;
	localparam status_t STATUS_EMPTY   = 2'd2;
	localparam status_t STATUS_UNKNOWN = 2'd3;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_HIT,
		WR_APPEND,
		WR_MOVE
	} wr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_CLR
	} cnt_op_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;
		logic    step;
		logic    take_hit;
		logic    latch_res;
		logic    rd_last;
		logic    emit;
		wr_op_t  wr;
		cnt_op_t cnt;
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic hit;
		logic full;
		logic empty;
		logic rd_hit;
		logic can_issue;
		logic out_free;
	} sts_t;

endpackage

### design/kvt_req_if.sv
// kvt_req_if: command channel (command, key, value) with valid/ready.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

interface kvt_req_if #(
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	kvt_pkg::cmd_t          command;
	logic [KEY_WIDTH-1:0]   key;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink   (input valid, input command, input key, input value, output ready);
endinterface

### design/kvt_rsp_if.sv
// kvt_rsp_if: result channel (status, found, value_out, entry_count) with valid/ready.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

interface kvt_rsp_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                   valid;
	logic                   ready;
	kvt_pkg::status_t       status;
	logic                   found;
	logic [VALUE_WIDTH-1:0] value_out;
	kvt_pkg::cnt_t          entry_count;

	modport source (output valid, output status, output found, output value_out,
		output entry_count, input ready);
	modport sink   (input valid, input status, input found, input value_out,
		input entry_count, output ready);
endinterface

### design/kvt_cfg_if.sv
// kvt_cfg_if: capacity register write channel with valid/ready.
// Depends on kvt_pkg.
`timescale 1ns / 1ps

interface kvt_cfg_if;
	logic          valid;
	logic          ready;
	kvt_pkg::cnt_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### design/key_value_table_top.sv
// key_value_table_top: linear-search key/value table, controller plus datapath.
// Depends on kvt_pkg, kvt_req_if, kvt_rsp_if, kvt_cfg_if, kvt_controller, kvt_datapath.
//
//   channel | dir | payload                                  | accepted when
//   req     | in  | command, key, value                      | req.valid && req.ready
//   rsp     | out | status, found, value_out, entry_count    | rsp.valid && rsp.ready
//   cfg     | in  | data (capacity)                          | cfg.valid (ready tied high)
//
// The memory read port scans one entry a cycle, n entries per search (count on a miss,
// match index + 1 on a hit); a remove that hits moves the last entry into the hit slot.
// arst_n clears count, capacity (to 16), control state and the result valid.
// A stalled result sits in the output register; the next item is taken and searched
// meanwhile and waits at its end until the register frees.
`timescale 1ns / 1ps

module key_value_table_top #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	kvt_req_if.sink   req,
	kvt_rsp_if.source rsp,
	kvt_cfg_if.sink   cfg
);

	kvt_pkg::ctl_t ctl;
	kvt_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	kvt_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	kvt_datapath #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.req_command     (req.command),
		.req_key         (req.key),
		.req_value       (req.value),
		.cfg_valid       (cfg.valid),
		.cfg_data        (cfg.data),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_found       (rsp.found),
		.rsp_value_out   (rsp.value_out),
		.rsp_entry_count (rsp.entry_count)
	);

endmodule

### design/kvt_datapath.sv
// kvt_datapath: entry memory, count, capacity, search pipeline and result register.
// Driven by kvt_controller through kvt_pkg::ctl_t; depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_datapath #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kvt_pkg::ctl_t          ctl,
	output kvt_pkg::sts_t          sts,
	input  kvt_pkg::cmd_t          req_command,
	input  logic [KEY_WIDTH-1:0]   req_key,
	input  logic [VALUE_WIDTH-1:0] req_value,
	input  logic                   cfg_valid,
	input  kvt_pkg::cnt_t          cfg_data,
	input  logic                   rsp_ready,
	output logic                   rsp_valid,
	output kvt_pkg::status_t       rsp_status,
	output logic                   rsp_found,
	output logic [VALUE_WIDTH-1:0] rsp_value_out,
	output kvt_pkg::cnt_t          rsp_entry_count
);

	localparam int IDXW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ENTRY_W = KEY_WIDTH + VALUE_WIDTH;
	localparam int SAT     = (DEPTH < 31) ? DEPTH : 31;
	localparam kvt_pkg::cnt_t CAP_LIMIT = kvt_pkg::cnt_t'(SAT);

	logic [ENTRY_W-1:0] mem [DEPTH];

	kvt_pkg::cmd_t          cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	kvt_pkg::cnt_t          cap_q;
	kvt_pkg::cnt_t          count_q;
	kvt_pkg::cnt_t          idx_q;
	kvt_pkg::cnt_t          rd_idx_s1;
	logic                   rd_valid_s1;
	logic [ENTRY_W-1:0]     rd_data_s1;
	logic                   hit_q;
	kvt_pkg::cnt_t          hit_idx_q;
	logic [VALUE_WIDTH-1:0] hit_val_q;

	kvt_pkg::status_t       res_status_q;
	logic                   res_found_q;
	logic [VALUE_WIDTH-1:0] res_val_q;

	logic                   rsp_valid_q;
	kvt_pkg::status_t       rsp_status_q;
	logic                   rsp_found_q;
	logic [VALUE_WIDTH-1:0] rsp_val_q;
	kvt_pkg::cnt_t          rsp_count_q;

	kvt_pkg::cnt_t          eff_cap;
	kvt_pkg::cnt_t          last_idx;
	logic [IDXW-1:0]        rd_addr;
	logic [IDXW-1:0]        wr_addr;
	logic [ENTRY_W-1:0]     wr_data;
	logic                   wr_en;
	logic                   full;
	logic                   empty;

	kvt_pkg::status_t       nxt_status;
	logic                   nxt_found;
	logic [VALUE_WIDTH-1:0] nxt_val;

	assign eff_cap  = (cap_q < CAP_LIMIT) ? cap_q : CAP_LIMIT;
	assign full     = (count_q >= eff_cap);
	assign empty    = (count_q == '0);
	assign last_idx = count_q - kvt_pkg::cnt_t'(1);

	assign sts.cmd       = cmd_q;
	assign sts.hit       = hit_q;
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.rd_hit    = rd_valid_s1 && (rd_data_s1[ENTRY_W-1:VALUE_WIDTH] == key_q);
	assign sts.can_issue = (idx_q < count_q);
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rd_addr = ctl.rd_last ? IDXW'(last_idx) : IDXW'(idx_q);
	assign wr_addr = (ctl.wr == kvt_pkg::WR_APPEND) ? IDXW'(count_q) : IDXW'(hit_idx_q);
	assign wr_data = (ctl.wr == kvt_pkg::WR_MOVE) ? rd_data_s1 : {key_q, val_q};
	assign wr_en   = (ctl.wr != kvt_pkg::WR_NONE);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.step || ctl.rd_last) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_comb begin
		nxt_status = kvt_pkg::STATUS_OK;
		nxt_found  = 1'b0;
		nxt_val    = '0;
		case (cmd_q)
			kvt_pkg::CMD_PUT: begin
				nxt_found = hit_q;
				if (full) begin
					nxt_status = kvt_pkg::STATUS_FULL;
				end
			end
			kvt_pkg::CMD_GET, kvt_pkg::CMD_REMOVE: begin
				if (empty) begin
					nxt_status = kvt_pkg::STATUS_EMPTY;
				end else if (!hit_q) begin
					nxt_status = kvt_pkg::STATUS_UNKNOWN;
				end else begin
					nxt_found = 1'b1;
					nxt_val   = hit_val_q;
				end
			end
			kvt_pkg::CMD_CONTAINS: begin
				nxt_found = hit_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= kvt_pkg::CAP_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			case (ctl.cnt)
				kvt_pkg::CNT_INC: count_q <= count_q + kvt_pkg::cnt_t'(1);
				kvt_pkg::CNT_DEC: count_q <= last_idx;
				kvt_pkg::CNT_CLR: count_q <= '0;
				default:          count_q <= count_q;
			endcase
			if (ctl.load) begin
				idx_q <= '0;
			end else if (ctl.step) begin
				idx_q <= idx_q + kvt_pkg::cnt_t'(1);
			end
			rd_valid_s1 <= ctl.step;
			if (ctl.load) begin
				hit_q <= 1'b0;
			end else if (ctl.take_hit) begin
				hit_q <= 1'b1;
			end
			if (ctl.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req_command;
			key_q <= req_key;
			val_q <= req_value;
		end
		if (ctl.step) begin
			rd_idx_s1 <= idx_q;
		end
		if (ctl.take_hit) begin
			hit_idx_q <= rd_idx_s1;
			hit_val_q <= rd_data_s1[VALUE_WIDTH-1:0];
		end
		if (ctl.latch_res) begin
			res_status_q <= nxt_status;
			res_found_q  <= nxt_found;
			res_val_q    <= nxt_val;
		end
		if (ctl.emit) begin
			rsp_status_q <= res_status_q;
			rsp_found_q  <= res_found_q;
			rsp_val_q    <= res_val_q;
			rsp_count_q  <= count_q;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp_status      = rsp_status_q;
	assign rsp_found       = rsp_found_q;
	assign rsp_value_out   = rsp_val_q;
	assign rsp_entry_count = rsp_count_q;

endmodule

### design/kvt_controller.sv
// kvt_controller: state machine that sequences search, update and result of one item.
// Drives kvt_datapath through kvt_pkg::ctl_t; depends on kvt_pkg.
`timescale 1ns / 1ps

module kvt_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  kvt_pkg::sts_t sts,
	output kvt_pkg::ctl_t ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_MOVE,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (sts.rd_hit) begin
					ctl.take_hit = 1'b1;
					state_nxt    = ST_DECIDE;
				end else if (!sts.can_issue) begin
					state_nxt = ST_DECIDE;
				end else begin
					ctl.step = 1'b1;
				end
			end
			ST_DECIDE: begin
				ctl.latch_res = 1'b1;
				state_nxt     = ST_FINISH;
				case (sts.cmd)
					kvt_pkg::CMD_PUT: begin
						if (!sts.full) begin
							ctl.wr  = sts.hit ? kvt_pkg::WR_HIT : kvt_pkg::WR_APPEND;
							ctl.cnt = sts.hit ? kvt_pkg::CNT_HOLD : kvt_pkg::CNT_INC;
						end
					end
					kvt_pkg::CMD_REMOVE: begin
						if (!sts.empty && sts.hit) begin
							ctl.rd_last = 1'b1;
							state_nxt   = ST_MOVE;
						end
					end
					kvt_pkg::CMD_CLEAR: begin
						ctl.cnt = kvt_pkg::CNT_CLR;
					end
					default: begin
					end
				endcase
			end
			ST_MOVE: begin
				ctl.wr    = kvt_pkg::WR_MOVE;
				ctl.cnt   = kvt_pkg::CNT_DEC;
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					ctl.emit  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
